FILE: hw/rtl/ccu_pkg.sv
// shared types, constants and arctangent table for the circular cordic unit
package ccu_pkg;

  localparam int ITERATIONS_DEF = 15;
  localparam int FRACTION_BITS  = 8;
  localparam int DATA_W         = 24;
  localparam int ATAN_LEN       = 24;

  typedef logic signed [DATA_W-1:0] word_t;

  localparam word_t GAIN_Q = word_t'(155);
  localparam word_t DEG90  = word_t'(90 * (1 << FRACTION_BITS));
  localparam word_t DEG180 = word_t'(180 * (1 << FRACTION_BITS));
  localparam word_t DEG270 = word_t'(270 * (1 << FRACTION_BITS));
  localparam word_t DEG360 = word_t'(360 * (1 << FRACTION_BITS));

  typedef enum logic [2:0] {
    OP_ATAN  = 3'd0,
    OP_HYPOT = 3'd1,
    OP_COS   = 3'd2,
    OP_SIN   = 3'd3,
    OP_ASIN  = 3'd4,
    OP_ACOS  = 3'd5
  } op_t;

  typedef struct packed {
    op_t   op;
    word_t x;
    word_t y;
    word_t ang;
    word_t tgt;
  } stage_t;

  // arctangent of 2^-idx in degrees times 256
  function automatic word_t atan_entry(input int idx);
    case (idx)
      0:       return word_t'(11520);
      1:       return word_t'(6801);
      2:       return word_t'(3593);
      3:       return word_t'(1824);
      4:       return word_t'(916);
      5:       return word_t'(458);
      6:       return word_t'(229);
      7:       return word_t'(115);
      8:       return word_t'(57);
      9:       return word_t'(29);
      10:      return word_t'(14);
      11:      return word_t'(7);
      12:      return word_t'(4);
      13:      return word_t'(2);
      14:      return word_t'(1);
      default: return '0;
    endcase
  endfunction

endpackage

FILE: hw/rtl/circular_cordic_unit.sv
// circular cordic unit: atan, hypotenuse, cos, sin, asin and acos in q.8
// throughput: one operation per cycle while the result is not stalled;
// every iteration is its own pipeline cell
// a stalled result holds the whole pipeline; s_tready follows the output register
// reset clears every stage valid bit; data registers are not reset
module circular_cordic_unit
  import ccu_pkg::*;
#(
  parameter int ITERATIONS = ITERATIONS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // operand_a[19:0], operand_b[39:20]
  input  logic [2:0]  s_tuser,  // op[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // result[23:0]
);

  logic   adv;
  logic   chain_valid [ITERATIONS+1];
  stage_t chain_data  [ITERATIONS+1];
  word_t  result;

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  ccu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s_tvalid),
    .op        (s_tuser),
    .operand_a (s_tdata[19:0]),
    .operand_b (s_tdata[39:20]),
    .out_valid (chain_valid[0]),
    .out       (chain_data[0])
  );

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
    ccu_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .in_valid  (chain_valid[i]),
      .in        (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out       (chain_data[i+1])
    );
  end

  ccu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (chain_valid[ITERATIONS]),
    .in        (chain_data[ITERATIONS]),
    .out_valid (m_tvalid),
    .result    (result)
  );

  assign m_tdata = result;

endmodule

FILE: hw/rtl/ccu_front.sv
// input stages: angle fold into one turn and start vector per operation
module ccu_front
  import ccu_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [2:0]         op,
  input  logic signed [19:0] operand_a,
  input  logic signed [19:0] operand_b,
  output logic               out_valid,
  output stage_t             out
);

  localparam logic [21:0] FOLD_BIAS   = 22'(6 * 360 * (1 << FRACTION_BITS));
  localparam logic [11:0] RECIP       = 12'd2913;
  localparam int          RECIP_SHIFT = 20;
  localparam logic [12:0] TURN_DEG    = 13'd360;

  logic               v0;
  logic [2:0]         op0;
  logic signed [19:0] a0;
  logic signed [19:0] b0;
  logic [3:0]         q0;

  logic [20:0] fold_in;
  logic [24:0] quot_prod;
  logic [20:0] fold1;
  logic [12:0] rem_raw;
  logic [12:0] rem;
  logic [16:0] turn;
  word_t       ae;
  word_t       be;
  stage_t      s1;

  // quotient of the biased angle in whole turns
  assign fold_in   = 21'({{2{operand_a[19]}}, operand_a} + FOLD_BIAS);
  assign quot_prod = {12'd0, fold_in[20:8]} * {13'd0, RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op0 <= op;
      a0  <= operand_a;
      b0  <= operand_b;
      q0  <= quot_prod[RECIP_SHIFT+3:RECIP_SHIFT];
    end
  end

  assign fold1   = 21'({{2{a0[19]}}, a0} + FOLD_BIAS);
  assign rem_raw = fold1[20:8] - 13'(q0 * TURN_DEG);
  assign rem     = (rem_raw >= TURN_DEG) ? rem_raw - TURN_DEG : rem_raw;
  assign turn    = {rem[8:0], fold1[7:0]};
  assign ae      = {{4{a0[19]}}, a0};
  assign be      = {{4{b0[19]}}, b0};

  always_comb begin
    s1     = '0;
    s1.op  = op_t'(op0);
    unique case (op_t'(op0))
      OP_ATAN: begin
        s1.x = be[DATA_W-1] ? -be : be;
        s1.y = be[DATA_W-1] ? -ae : ae;
      end
      OP_HYPOT: begin
        s1.x = be[DATA_W-1] ? -be : be;
        s1.y = ae[DATA_W-1] ? -ae : ae;
      end
      OP_COS, OP_SIN: begin
        s1.x   = GAIN_Q;
        s1.tgt = {{(DATA_W-17){1'b0}}, turn};
        if (s1.tgt > DEG270) begin
          s1.ang = DEG360;
        end else if (s1.tgt > DEG90) begin
          s1.ang = DEG180;
        end
      end
      OP_ASIN: begin
        s1.x   = GAIN_Q;
        s1.tgt = ae;
      end
      OP_ACOS: begin
        s1.y   = GAIN_Q;
        s1.ang = DEG90;
        s1.tgt = ae;
      end
      default: begin
        s1.x = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out <= s1;
    end
  end

endmodule

FILE: hw/rtl/ccu_cell.sv
// one shift-add micro-rotation stage of the cordic chain
module ccu_cell
  import ccu_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  stage_t in,
  output logic   out_valid,
  output stage_t out
);

  localparam word_t STEP_ANGLE = atan_entry(SHIFT);

  logic   ccw;
  word_t  xs;
  word_t  ys;
  stage_t nxt;

  assign xs = in.x >>> SHIFT;
  assign ys = in.y >>> SHIFT;

  always_comb begin
    case (in.op)
      OP_ATAN, OP_HYPOT: ccw = !(in.y > 0);
      OP_COS, OP_SIN:    ccw = in.tgt > in.ang;
      OP_ASIN:           ccw = in.y < in.tgt;
      OP_ACOS:           ccw = in.x > in.tgt;
      default:           ccw = 1'b0;
    endcase
  end

  always_comb begin
    nxt     = in;
    nxt.x   = ccw ? in.x - ys : in.x + ys;
    nxt.y   = ccw ? in.y + xs : in.y - xs;
    nxt.ang = ccw ? in.ang + STEP_ANGLE : in.ang - STEP_ANGLE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out <= nxt;
    end
  end

endmodule

FILE: hw/rtl/ccu_back.sv
// output stage: quadrant sign, angle clamps and gain scaling
module ccu_back
  import ccu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  stage_t in,
  output logic   out_valid,
  output word_t  result
);

  logic [31:0] gain_prod;
  word_t       res_next;

  assign gain_prod = {{(32-DATA_W){in.x[DATA_W-1]}}, in.x} * 32'(GAIN_Q);

  always_comb begin
    case (in.op)
      OP_ATAN:  res_next = in.ang;
      OP_HYPOT: res_next = gain_prod[DATA_W+FRACTION_BITS-1:FRACTION_BITS];
      OP_COS:   res_next = (in.tgt > DEG90 && in.tgt < DEG270) ? -in.x : in.x;
      OP_SIN:   res_next = (in.tgt > DEG90 && in.tgt <= DEG270) ? -in.y : in.y;
      OP_ASIN: begin
        if (in.ang < -DEG90) begin
          res_next = -DEG90;
        end else if (in.ang > DEG90) begin
          res_next = DEG90;
        end else begin
          res_next = in.ang;
        end
      end
      OP_ACOS: begin
        if (in.ang > DEG180) begin
          res_next = DEG180;
        end else if (in.ang < 0) begin
          res_next = '0;
        end else begin
          res_next = in.ang;
        end
      end
      default:  res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= res_next;
    end
  end

endmodule

FILE: hw/rtl/ccu_checker.sv
// port-level checks for the circular cordic unit and their bind
module ccu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // input side advances exactly when the output register can move
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output register");

endmodule

bind circular_cordic_unit ccu_checker u_ccu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
